@@ rtl/core/rrlt_pkg.sv @@
`timescale 1ns / 1ps

package rrlt_pkg;

  // operation codes
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOMATCH   = 2'd2;
  localparam logic [1:0] STAT_BADINDEX  = 2'd3;

  // one stored rectangle, inclusive bounds
  typedef struct packed {
    logic signed [31:0] x_min;
    logic signed [31:0] z_min;
    logic signed [31:0] x_max;
    logic signed [31:0] z_max;
  } rect_t;

  // per-cell command for one cycle
  typedef struct packed {
    logic load;    // take the new rectangle
    logic shift;   // take the upper neighbor's rectangle
    logic eval;    // compare the point and register the match
    logic active;  // cell holds a live entry
  } cell_ctl_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GROUP,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/rrlt_req_if.sv @@
`timescale 1ns / 1ps

interface rrlt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_z;
  logic               hint_valid;
  logic [5:0]         hint_index;
  logic [5:0]         entry_index;

  modport source (
    output valid, op, coord_x, coord_z, end_x, end_z, hint_valid, hint_index, entry_index,
    input  ready
  );
  modport sink (
    input  valid, op, coord_x, coord_z, end_x, end_z, hint_valid, hint_index, entry_index,
    output ready
  );
endinterface

@@ rtl/core/rrlt_rsp_if.sv @@
`timescale 1ns / 1ps

interface rrlt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] result_index;
  logic [6:0] entry_count;

  modport source (
    output valid, status, result_index, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, result_index, entry_count,
    output ready
  );
endinterface

@@ rtl/core/rectangle_region_lookup_table.sv @@
`timescale 1ns / 1ps

// Rectangle region lookup table.
// Channels: req (sink) carries one operation per transfer: create appends a
// rectangle, find returns the lowest entry holding a point (hint entry first),
// delete removes an entry and moves later entries down. rsp (source) returns
// one result per request: status, result_index, entry_count.
// Storage is a row of cells, one rectangle each; on delete every cell from
// the removed one up to the next-to-top live entry takes its upper neighbor's rectangle in the same cycle.
// Timing: a request is taken in the idle state; cells update and compare in
// the execute state, a two-level priority tree with a registered first level
// picks the lowest match in the group state, and the result is loaded into
// the output register in the done state. No new request is taken until the
// sequencer is back in idle; it handles one item at a time.
// Stall: the output register holds its result while rsp.ready is low; the
// next request is still taken and worked on, and waits in the last step
// until the output register is free.
// Reset (rst, synchronous): empties the table and drops any pending result.
// Stored rectangles are not cleared; entries at or above the count are never
// read.

module rectangle_region_lookup_table #(
  parameter int MAX_REGIONS = 64
) (
  input  logic  clk,
  input  logic  rst,
  rrlt_req_if.sink   req,
  rrlt_rsp_if.source rsp
);
  import rrlt_pkg::*;

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  state_t state, state_next;

  // latched request
  logic [1:0]         op;
  rect_t              item_rect;
  logic               hint_valid;
  logic [5:0]         hint_index;
  logic [5:0]         entry_index;

  logic [CW-1:0]      count;
  logic [1:0]         pre_status;
  logic [5:0]         pre_index;
  logic               hint_hit;
  logic               hint_hit_c;

  rect_t              cell_rect [MAX_REGIONS];
  cell_ctl_t          cell_ctl  [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] match;

  logic               prio_hit;
  logic [IW-1:0]      prio_index;

  logic               exec;
  logic               do_create;
  logic               do_delete;
  logic               out_free;
  logic [1:0]         fin_status;
  logic [5:0]         fin_index;

  assign exec      = (state == S_EXEC);
  assign do_create = exec && (op == OP_CREATE) && (int'(count) < MAX_REGIONS);
  assign do_delete = exec && (op == OP_DELETE) && (int'(entry_index) < int'(count));
  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req.valid) state_next = S_EXEC;
      S_EXEC:  state_next = S_GROUP;
      S_GROUP: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // request capture on transfer
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op          <= req.op;
      item_rect   <= '{x_min: req.coord_x, z_min: req.coord_z,
                       x_max: req.end_x,   z_max: req.end_z};
      hint_valid  <= req.hint_valid;
      hint_index  <= req.hint_index;
      entry_index <= req.entry_index;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_create) begin
      count <= count + 1'b1;
    end else if (do_delete) begin
      count <= count - 1'b1;
    end
  end

  // status of create, find, delete and unused codes, settled in the execute cycle
  always_ff @(posedge clk) begin
    if (exec) begin
      unique case (op)
        OP_CREATE: begin
          if (int'(count) < MAX_REGIONS) begin
            pre_status <= STAT_OK;
            pre_index  <= 6'(count);
          end else begin
            pre_status <= STAT_FULL;
            pre_index  <= '0;
          end
        end
        OP_FIND: begin
          pre_status <= STAT_OK;
          pre_index  <= '0;
        end
        OP_DELETE: begin
          if (int'(entry_index) < int'(count)) begin
            pre_status <= STAT_OK;
          end else begin
            pre_status <= STAT_BADINDEX;
          end
          pre_index <= '0;
        end
        default: begin
          pre_status <= STAT_BADINDEX;
          pre_index  <= '0;
        end
      endcase
    end
  end

  // per-cell commands
  always_comb begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      cell_ctl[i].active = (i < int'(count));
      cell_ctl[i].eval   = exec && (op == OP_FIND);
      cell_ctl[i].load   = do_create && (i == int'(count));
      cell_ctl[i].shift  = do_delete && (i >= int'(entry_index)) && (i + 1 < int'(count));
    end
  end

  // row of cells; each reads its upper neighbor
  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    rect_t upper;
    if (g + 1 < MAX_REGIONS) begin : g_up
      assign upper = cell_rect[g + 1];
    end else begin : g_top
      assign upper = '0;
    end
    rrlt_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .new_rect   (item_rect),
      .upper_rect (upper),
      .px         (item_rect.x_min),
      .pz         (item_rect.z_min),
      .rect       (cell_rect[g]),
      .match      (match[g])
    );
  end

  // lowest matching entry
  rrlt_prio #(
    .N (MAX_REGIONS)
  ) u_prio (
    .clk   (clk),
    .match (match),
    .step  (state == S_GROUP),
    .hit   (prio_hit),
    .index (prio_index)
  );

  // hint test against the registered match flags
  always_comb begin
    hint_hit_c = 1'b0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if ((int'(hint_index) == i) && match[i]) begin
        hint_hit_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_GROUP) begin
      hint_hit <= hint_valid && hint_hit_c;
    end
  end

  // final result
  always_comb begin
    fin_status = pre_status;
    fin_index  = pre_index;
    if (op == OP_FIND) begin
      if (hint_hit) begin
        fin_index = hint_index;
      end else if (prio_hit) begin
        fin_index = 6'(prio_index);
      end else begin
        fin_status = STAT_NOMATCH;
        fin_index  = '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.status       <= fin_status;
      rsp.result_index <= fin_index;
      rsp.entry_count  <= 7'(count);
    end
  end

endmodule

@@ rtl/core/rrlt_cell.sv @@
`timescale 1ns / 1ps

module rrlt_cell (
  input  logic              clk,
  input  rrlt_pkg::cell_ctl_t ctl,
  input  rrlt_pkg::rect_t   new_rect,
  input  rrlt_pkg::rect_t   upper_rect,
  input  logic signed [31:0] px,
  input  logic signed [31:0] pz,
  output rrlt_pkg::rect_t   rect,
  output logic              match
);
  import rrlt_pkg::*;

  logic inside_pt;

  // point containment against own bounds
  assign inside_pt = (px >= rect.x_min) && (px <= rect.x_max) &&
                     (pz >= rect.z_min) && (pz <= rect.z_max);

  // rectangle storage: append or shift down from neighbor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rect <= new_rect;
    end else if (ctl.shift) begin
      rect <= upper_rect;
    end
  end

  // registered match flag
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      match <= ctl.active && inside_pt;
    end
  end

endmodule

@@ rtl/core/rrlt_prio.sv @@
`timescale 1ns / 1ps

module rrlt_prio #(
  parameter int N = 64
) (
  input  logic                              clk,
  input  logic [N-1:0]                      match,
  input  logic                              step,
  output logic                              hit,
  output logic [((N > 1) ? $clog2(N) : 1)-1:0] index
);
  import rrlt_pkg::*;

  localparam int G  = (N + 7) / 8;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int GW = (G > 1) ? $clog2(G) : 1;

  logic [G*8-1:0] padded;
  logic [G-1:0]   gh_c;
  logic [2:0]     gl_c [G];
  logic [G-1:0]   grp_hit;
  logic [2:0]     grp_low [G];
  logic [GW-1:0]  gsel;

  // pad match vector to whole groups of eight
  always_comb begin
    padded = '0;
    for (int i = 0; i < N; i++) begin
      padded[i] = match[i];
    end
  end

  // first level: lowest set bit in each group
  always_comb begin
    for (int g = 0; g < G; g++) begin
      gh_c[g] = |padded[g*8 +: 8];
      gl_c[g] = '0;
      for (int j = 7; j >= 0; j--) begin
        if (padded[g*8 + j]) begin
          gl_c[g] = 3'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      grp_hit <= gh_c;
      grp_low <= gl_c;
    end
  end

  // second level: lowest group with a hit
  always_comb begin
    gsel = '0;
    for (int g = G - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        gsel = GW'(g);
      end
    end
  end

  assign hit   = |grp_hit;
  assign index = IW'(int'(gsel) * 8 + int'(grp_low[gsel]));

endmodule

@@ rtl/core/rrlt_checker.sv @@
`timescale 1ns / 1ps

module rrlt_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] status,
  input logic [5:0] result_index
);
  import rrlt_pkg::*;

  // a pending result stays until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // reset leaves no pending result
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");

  // one request at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // failed operations report index zero
  a_fail_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STAT_OK |-> result_index == 6'd0)
    else $error("nonzero index on failure");

endmodule

bind rectangle_region_lookup_table rrlt_checker u_rrlt_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .result_index (rsp.result_index)
);
